// ----- rtl/core/fpmd_pkg.sv -----
// Shared types and constants of the field pair match detector.
`timescale 1ns / 1ps

package fpmd_pkg;

  localparam int SumW    = 32;
  localparam int HeightW = 13;
  localparam int RowW    = 12;
  localparam int PixW    = 8;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_NOISE  = 2'd0;
  localparam logic [1:0] REG_SKIP   = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [7:0]  NOISE_RST  = 8'd3;
  localparam logic [1:0]  SKIP_RST   = 2'd1;
  localparam logic [12:0] HEIGHT_RST = 13'd480;

  // Match codes
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_TOP    = 2'd1;
  localparam logic [1:0] KIND_BOTTOM = 2'd2;

  typedef struct packed {
    logic [7:0]  noise_level;
    logic [1:0]  skip_mode;
    logic [12:0] frame_height;
  } fpmd_cfg_t;

  typedef struct packed {
    logic            fire;
    logic [SumW-1:0] even_sum;
    logic [SumW-1:0] odd_sum;
  } fpmd_sums_t;

endpackage

// ----- rtl/core/fpmd_if.sv -----
// Stream interfaces for pixel pair requests and frame results.
`timescale 1ns / 1ps

interface fpmd_pixel_if;
  logic        valid;
  logic        ready;
  logic [7:0]  left_pixel;
  logic [7:0]  right_pixel;
  logic [11:0] row_index;
  logic        frame_end;

  modport source(output valid, left_pixel, right_pixel, row_index, frame_end, input ready);
  modport sink(input valid, left_pixel, right_pixel, row_index, frame_end, output ready);
endinterface

interface fpmd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  match_kind;
  logic [31:0] even_sum;
  logic [31:0] odd_sum;

  modport source(output valid, match_kind, even_sum, odd_sum, input ready);
  modport sink(input valid, match_kind, even_sum, odd_sum, output ready);
endinterface

// ----- rtl/core/fpmd_cfg.sv -----
// APB-style configuration register bank.
`timescale 1ns / 1ps

module fpmd_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output fpmd_pkg::fpmd_cfg_t cfg
);
  import fpmd_pkg::*;

  logic [1:0] index;
  logic       wr_en;
  logic [7:0] noise_level;
  logic [1:0] skip_mode;
  logic [12:0] frame_height;

  assign pready = 1'b1;
  assign index  = paddr[3:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_level  <= NOISE_RST;
      skip_mode    <= SKIP_RST;
      frame_height <= HEIGHT_RST;
    end else if (wr_en) begin
      case (index)
        REG_NOISE:  noise_level  <= pwdata[7:0];
        REG_SKIP:   skip_mode    <= pwdata[1:0];
        REG_HEIGHT: frame_height <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_NOISE:  prdata = {24'd0, noise_level};
      REG_SKIP:   prdata = {30'd0, skip_mode};
      REG_HEIGHT: prdata = {19'd0, frame_height};
      default:    prdata = 32'd0;
    endcase
  end

  assign cfg.noise_level  = noise_level;
  assign cfg.skip_mode    = skip_mode;
  assign cfg.frame_height = frame_height;

endmodule

// ----- rtl/core/fpmd_accum.sv -----
// Input register, row qualification and saturating field accumulators.
`timescale 1ns / 1ps

module fpmd_accum #(
  parameter int MAX_ROWS = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  fpmd_pkg::fpmd_cfg_t   cfg,
  fpmd_pixel_if.sink            pixel,
  input  logic                  s2_free,
  output fpmd_pkg::fpmd_sums_t  sums
);
  import fpmd_pkg::*;

  // Height cap only matters below the 13-bit field range
  localparam int HCap = (MAX_ROWS > 8191) ? 8191 : MAX_ROWS;
  localparam logic [12:0] HCapV = 13'(HCap);

  logic        v1;
  logic [7:0]  left_q;
  logic [7:0]  right_q;
  logic [11:0] row_q;
  logic        end_q;

  logic [31:0] even_acc;
  logic [31:0] odd_acc;
  logic [31:0] even_acc_next;
  logic [31:0] odd_acc_next;

  logic [1:0]  m;
  logic [12:0] h;
  logic [12:0] h_scaled;
  logic [2:0]  mask;
  logic [7:0]  delta;
  logic        pass;
  logic [11:0] row_m1;
  logic        even_hit;
  logic        odd_hit;
  logic [32:0] even_add;
  logic [32:0] odd_add;
  logic        s1_go;

  always_comb begin
    m        = (cfg.skip_mode > 2'd2) ? 2'd2 : cfg.skip_mode;
    h        = (cfg.frame_height > HCapV) ? HCapV : cfg.frame_height;
    h_scaled = h >> m;
    mask     = (3'd2 << m) - 3'd1;
    delta    = (left_q > right_q) ? (left_q - right_q) : (right_q - left_q);
    pass     = delta > cfg.noise_level;
    row_m1   = row_q - 12'd1;
    even_hit = pass && ((row_q[2:0] & mask) == 3'd0) &&
               (({1'b0, row_q >> m} + 13'd1) < h_scaled);
    odd_hit  = pass && (row_q != 12'd0) && ((row_m1[2:0] & mask) == 3'd0) &&
               (({1'b0, row_m1 >> m} + 13'd1) < h_scaled);
    even_add = {1'b0, even_acc} + {25'd0, delta};
    odd_add  = {1'b0, odd_acc} + {25'd0, delta};
    even_acc_next = even_hit ? (even_add[32] ? '1 : even_add[31:0]) : even_acc;
    odd_acc_next  = odd_hit ? (odd_add[32] ? '1 : odd_add[31:0]) : odd_acc;
  end

  // A frame end item waits until the sum stage has room
  assign s1_go       = v1 && (!end_q || s2_free);
  assign pixel.ready = !rst && (!v1 || s1_go);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (pixel.ready) begin
      v1 <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel.ready) begin
      left_q  <= pixel.left_pixel;
      right_q <= pixel.right_pixel;
      row_q   <= pixel.row_index;
      end_q   <= pixel.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      even_acc <= '0;
      odd_acc  <= '0;
    end else if (s1_go) begin
      even_acc <= end_q ? '0 : even_acc_next;
      odd_acc  <= end_q ? '0 : odd_acc_next;
    end
  end

  assign sums.fire     = s1_go && end_q;
  assign sums.even_sum = even_acc_next;
  assign sums.odd_sum  = odd_acc_next;

endmodule

// ----- rtl/core/fpmd_decide.sv -----
// Frame sum register, ten-times comparison and result register.
`timescale 1ns / 1ps

module fpmd_decide (
  input  logic                 clk,
  input  logic                 rst,
  input  fpmd_pkg::fpmd_sums_t sums,
  output logic                 s2_free,
  fpmd_result_if.source        result
);
  import fpmd_pkg::*;

  logic        v2;
  logic [31:0] top;
  logic [31:0] bot;
  logic        s2_go;
  logic [35:0] top_w;
  logic [35:0] bot_w;
  logic [35:0] top_x10;
  logic [35:0] bot_x10;
  logic [1:0]  kind;
  logic        ov;
  logic [1:0]  match_kind;
  logic [31:0] even_sum;
  logic [31:0] odd_sum;

  assign s2_go   = v2 && (!ov || result.ready);
  assign s2_free = !v2 || s2_go;

  always_comb begin
    top_w   = {4'd0, top};
    bot_w   = {4'd0, bot};
    top_x10 = (top_w << 3) + (top_w << 1);
    bot_x10 = (bot_w << 3) + (bot_w << 1);
    kind    = KIND_NONE;
    if (top_w > bot_x10) kind = KIND_BOTTOM;
    if (bot_w > top_x10) kind = KIND_TOP;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (s2_free) begin
      v2 <= sums.fire;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && sums.fire) begin
      top <= sums.even_sum;
      bot <= sums.odd_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (s2_go) begin
      ov <= 1'b1;
    end else if (result.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      match_kind <= kind;
      even_sum   <= top;
      odd_sum    <= bot;
    end
  end

  assign result.valid      = ov;
  assign result.match_kind = match_kind;
  assign result.even_sum   = even_sum;
  assign result.odd_sum    = odd_sum;

endmodule

// ----- rtl/core/field_pair_match_detector_core.sv -----
// Top level of the field pair match detector.
`timescale 1ns / 1ps

// Field pair match detector: takes one co-located luma pixel pair of two
// frames per clock, with its row and a frame end mark. Absolute differences
// above noise_level add, with saturation at 32 bits, into a top-field sum
// (rows 0, 2^(m+1), ..., m being skip_mode capped at 2) and a bottom-field
// sum (those rows plus one), for rows whose scaled base row lies below
// (min(frame_height, MAX_ROWS) >> m) - 1. The frame end request emits one
// result: both sums and a match code (bottom when top exceeds ten times
// bottom, top when bottom exceeds ten times top, else none), and clears the
// sums. Throughput is one pixel pair per clock outside the stall below; a
// request passes the input register, the accumulator update and, for a frame
// end, the sum register and result register, which drives result valid.
// The input side stalls only while a finished result waits at the output,
// the next frame's sums sit in the sum register behind it, and a third frame
// end request reaches the input register. Registers sit on an APB-style port:
// noise_level at 0x0, skip_mode at 0x4, frame_height at 0x8; write them
// only while the block is idle. No clearing pass follows reset.

module field_pair_match_detector_core #(
  parameter int MAX_ROWS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  fpmd_pixel_if.sink    pixel,
  fpmd_result_if.source result
);
  import fpmd_pkg::*;

  fpmd_cfg_t  cfg;
  fpmd_sums_t sums;
  logic       s2_free;

  // Hold the register bank
  fpmd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Register the request, qualify its row and advance both sums
  fpmd_accum #(
    .MAX_ROWS (MAX_ROWS)
  ) u_accum (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .pixel   (pixel),
    .s2_free (s2_free),
    .sums    (sums)
  );

  // Compare the frame sums and drive the result register
  fpmd_decide u_decide (
    .clk     (clk),
    .rst     (rst),
    .sums    (sums),
    .s2_free (s2_free),
    .result  (result)
  );

  // Input backpressure only arises behind a waiting result
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    !pixel.ready |-> result.valid)
    else $error("input stalled without a pending result");

  // A bottom match means the top sum really dominates
  a_bottom_order: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.match_kind == KIND_BOTTOM) |->
    (result.even_sum > result.odd_sum))
    else $error("bottom match with top sum not larger");

  a_top_order: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.match_kind == KIND_TOP) |->
    (result.odd_sum > result.even_sum))
    else $error("top match with bottom sum not larger");

  // No result leaves the block right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid after reset");

endmodule

// ----- tb/tb_field_pair_match_detector_core.sv -----
// Self-checking testbench for the field pair match detector core.
`timescale 1ns / 1ps

module tb_field_pair_match_detector_core;
  import fpmd_pkg::*;

  localparam int MaxRows = 4096;
  // Index 3 maps to no register; writes there must leave the setup alone.
  localparam logic [1:0] REG_UNUSED = 2'd3;
  // Cycles that a request may still spend inside the block after the last result.
  localparam int SettleCycles = 8;
  // Receiver hold-off long enough to back the block up into its input.
  localparam int LongHold = 300;
  localparam int PhaseItems = 175;
  localparam int NumPhases = 11;

  typedef struct packed {
    logic [7:0]  left_pixel;
    logic [7:0]  right_pixel;
    logic [11:0] row_index;
    logic        frame_end;
  } pixel_req_t;

  typedef struct packed {
    logic [1:0]  match_kind;
    logic [31:0] even_sum;
    logic [31:0] odd_sum;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  fpmd_pixel_if  pixel_bus ();
  fpmd_result_if result_bus ();

  field_pair_match_detector_core #(
    .MAX_ROWS(MaxRows)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .pixel  (pixel_bus),
    .result (result_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  // Shadow copy of the register file and of the two field sums.
  logic [7:0]  noise_cfg = NOISE_RST;
  logic [1:0]  skip_cfg = SKIP_RST;
  logic [12:0] height_cfg = HEIGHT_RST;
  logic [31:0] top_sum_acc = '0;
  logic [31:0] bottom_sum_acc = '0;

  pixel_req_t    pixel_backlog[$];
  frame_result_t frame_results_due[$];

  pixel_req_t pair_in_flight = '0;
  bit         pair_held = 1'b0;
  int         tx_gap = 0;
  int         rx_gap = 0;
  int         hold_left = 0;
  bit         long_hold_req = 1'b0;
  bit         no_idle = 1'b0;
  int         mismatch_count = 0;

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    mismatch_count++;
  endtask

  function automatic logic [31:0] sat_add32(logic [31:0] a, logic [7:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {25'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // A base row counts when its scaled index lies below (height >> mode) - 1.
  function automatic bit row_takes_part(int unsigned base, int unsigned m, int unsigned h);
    return ((base >> m) + 1) < (h >> m);
  endfunction

  // Fold one accepted request into the field sums; on frame end, queue the
  // expected result and clear the sums.
  task automatic fold_pixel_pair(input pixel_req_t req);
    int unsigned m;
    int unsigned h;
    int unsigned mask;
    int unsigned row;
    logic [7:0]  delta;
    longint unsigned top;
    longint unsigned bot;
    frame_result_t res;
    m = (skip_cfg > 2'd2) ? 2 : skip_cfg;
    h = (height_cfg > MaxRows) ? MaxRows : height_cfg;
    mask = (2 << m) - 1;
    row = req.row_index;
    delta = (req.left_pixel > req.right_pixel) ? req.left_pixel - req.right_pixel
                                               : req.right_pixel - req.left_pixel;
    if (delta > noise_cfg) begin
      if ((row & mask) == 0 && row_takes_part(row, m, h))
        top_sum_acc = sat_add32(top_sum_acc, delta);
      if (row != 0 && ((row - 1) & mask) == 0 && row_takes_part(row - 1, m, h))
        bottom_sum_acc = sat_add32(bottom_sum_acc, delta);
    end
    if (req.frame_end) begin
      top = top_sum_acc;
      bot = bottom_sum_acc;
      res.match_kind = KIND_NONE;
      // Compare at 64 bits so ten times a sum never wraps.
      if (top > 10 * bot) res.match_kind = KIND_BOTTOM;
      if (bot > 10 * top) res.match_kind = KIND_TOP;
      res.even_sum = top_sum_acc;
      res.odd_sum = bottom_sum_acc;
      frame_results_due.push_back(res);
      top_sum_acc = '0;
      bottom_sum_acc = '0;
    end
  endtask

  // Driver: hold each request until accepted, then idle for a drawn gap.
  always @(posedge clk) begin
    if (rst) begin
      pair_held = 1'b0;
      tx_gap = 0;
      pixel_bus.valid <= 1'b0;
    end else begin
      if (pixel_bus.valid && pixel_bus.ready) begin
        fold_pixel_pair(pair_in_flight);
        pair_held = 1'b0;
        tx_gap = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (!pair_held) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pixel_backlog.size() != 0) begin
          pair_in_flight = pixel_backlog.pop_front();
          pair_held = 1'b1;
        end
      end
      pixel_bus.valid <= pair_held;
      pixel_bus.left_pixel <= pair_in_flight.left_pixel;
      pixel_bus.right_pixel <= pair_in_flight.right_pixel;
      pixel_bus.row_index <= pair_in_flight.row_index;
      pixel_bus.frame_end <= pair_in_flight.frame_end;
    end
  end

  // Monitor: check each accepted result against the oldest expectation and
  // throttle ready with per-result gaps plus one long hold-off on request.
  always @(posedge clk) begin
    frame_result_t due;
    bit            rdy;
    if (rst) begin
      rx_gap = 0;
      hold_left = 0;
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (frame_results_due.size() == 0) begin
          flag_mismatch("result with no frame pending, even_sum", result_bus.even_sum, 0);
        end else begin
          due = frame_results_due.pop_front();
          if (result_bus.match_kind !== due.match_kind)
            flag_mismatch("match_kind", result_bus.match_kind, due.match_kind);
          if (result_bus.even_sum !== due.even_sum)
            flag_mismatch("even_sum", result_bus.even_sum, due.even_sum);
          if (result_bus.odd_sum !== due.odd_sum)
            flag_mismatch("odd_sum", result_bus.odd_sum, due.odd_sum);
        end
        rx_gap = no_idle ? 0 : $urandom_range(0, 4);
      end
      rdy = 1'b0;
      if (hold_left > 0) begin
        hold_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LongHold;
      end else if (rx_gap > 0) begin
        rx_gap--;
      end else begin
        rdy = 1'b1;
      end
      result_bus.ready <= rdy;
    end
  end

  // APB write: setup cycle, access cycle, then drop the select.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_NOISE:  noise_cfg = data[7:0];
      REG_SKIP:   skip_cfg = data[1:0];
      REG_HEIGHT: height_cfg = data[12:0];
      default: ;
    endcase
  endtask

  // Write all three registers; upper data bits carry junk half the time.
  task automatic set_config(input logic [7:0] nz, input logic [1:0] sk,
                            input logic [12:0] ht);
    logic [31:0] junk;
    junk = $urandom_range(0, 1) ? $urandom : 32'd0;
    write_reg(REG_NOISE, {junk[31:8], nz});
    write_reg(REG_SKIP, {junk[29:0], sk});
    write_reg(REG_HEIGHT, {junk[18:0], ht});
  endtask

  task automatic queue_pair(input logic [7:0] l, input logic [7:0] r,
                            input logic [11:0] row, input logic fe);
    pixel_req_t req;
    req.left_pixel = l;
    req.right_pixel = r;
    req.row_index = row;
    req.frame_end = fe;
    pixel_backlog.push_back(req);
  endtask

  // Queue one frame of random pairs. Styles: plain random, top-heavy,
  // bottom-heavy, and scattered rows over the whole index range.
  task automatic queue_frame(input int len, input int span_hi);
    pixel_req_t req;
    int         style;
    int         i;
    bit         open_end;
    bit         favored;
    logic [7:0] lo;
    logic [7:0] hi;
    style = $urandom_range(0, 3);
    // Now and then leave the frame open so its sums run into the next one.
    open_end = ($urandom_range(0, 7) == 0);
    for (i = 0; i < len; i++) begin
      if (style == 3 || $urandom_range(0, 15) == 0)
        req.row_index = 12'($urandom);
      else
        req.row_index = 12'($urandom_range(0, span_hi));
      if (style == 1 || style == 2) begin
        favored = (req.row_index[0] == (style == 2));
        lo = 8'($urandom_range(0, 60));
        hi = 8'($urandom_range(190, 255));
        if (!favored) begin
          req.left_pixel = 8'($urandom);
          req.right_pixel = req.left_pixel;
        end else if ($urandom_range(0, 1)) begin
          req.left_pixel = lo;
          req.right_pixel = hi;
        end else begin
          req.left_pixel = hi;
          req.right_pixel = lo;
        end
      end else begin
        req.left_pixel = 8'($urandom);
        // Land on or just past the noise level a third of the time.
        if ($urandom_range(0, 2) == 0)
          req.right_pixel = req.left_pixel + noise_cfg + 8'($urandom_range(0, 1));
        else
          req.right_pixel = 8'($urandom);
      end
      req.frame_end = (i == len - 1) && !open_end;
      pixel_backlog.push_back(req);
    end
  endtask

  // Wait until every request is accepted and every result has come, then
  // let the block's pipeline run dry.
  task automatic settle();
    while (pixel_backlog.size() != 0 || pair_held || frame_results_due.size() != 0)
      @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  initial begin
    int          p;
    int          phase_items;
    int          len;
    int          span_hi;
    int          h_eff;
    logic [7:0]  nz;
    logic [1:0]  sk;
    logic [12:0] ht;
    pixel_bus.valid = 1'b0;
    pixel_bus.left_pixel = '0;
    pixel_bus.right_pixel = '0;
    pixel_bus.row_index = '0;
    pixel_bus.frame_end = 1'b0;
    result_bus.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part under reset settings: noise 3, fast skip, 480 lines.
    queue_pair(8'd255, 8'd0, 12'd0, 1'b1);    // top only: bottom match
    queue_pair(8'd0, 8'd255, 12'd1, 1'b1);    // bottom only: top match
    queue_pair(8'd40, 8'd10, 12'd0, 1'b0);    // equal sums: no match
    queue_pair(8'd10, 8'd40, 12'd1, 1'b1);
    queue_pair(8'd10, 8'd13, 12'd0, 1'b1);    // difference at noise: dropped
    queue_pair(8'd10, 8'd14, 12'd4, 1'b1);    // just above noise on row 4
    queue_pair(8'd0, 8'd255, 12'd2, 1'b0);    // rows outside both fields
    queue_pair(8'd255, 8'd0, 12'd3, 1'b0);
    queue_pair(8'd0, 8'd255, 12'd4095, 1'b1);
    queue_pair(8'd200, 8'd100, 12'd476, 1'b0); // last rows inside the height
    queue_pair(8'd100, 8'd200, 12'd477, 1'b0);
    queue_pair(8'd0, 8'd255, 12'd480, 1'b0);   // first rows past it
    queue_pair(8'd0, 8'd255, 12'd481, 1'b1);
    queue_pair(8'd255, 8'd255, 12'd5, 1'b0);   // no frame end: sums carry over
    queue_pair(8'd0, 8'd255, 12'd5, 1'b0);
    settle();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    write_reg(REG_NOISE, 32'd0);
    queue_pair(8'd1, 8'd0, 12'd0, 1'b1);
    settle();
    // Skip mode three behaves as very fast mode.
    write_reg(REG_SKIP, 32'd3);
    queue_pair(8'd0, 8'd255, 12'd8, 1'b0);
    queue_pair(8'd0, 8'd255, 12'd9, 1'b0);
    queue_pair(8'd9, 8'd0, 12'd4, 1'b1);

    // Random phases, each with its own register setting.
    for (p = 0; p < NumPhases; p++) begin
      settle();
      nz = 8'($urandom_range(0, 63));
      sk = 2'($urandom_range(0, 3));
      ht = 13'($urandom_range(2, 64));
      case (p)
        0: begin nz = 8'd0; sk = 2'd0; ht = 13'd2; end
        1: begin nz = 8'd255; sk = 2'd2; ht = 13'd4096; end
        2: begin nz = 8'd3; sk = 2'd3; ht = 13'd8191; end
        3: sk = 2'd1;
        4: begin sk = 2'd0; ht = 13'd1; end
        5: begin nz = 8'd0; sk = 2'd2; ht = 13'd0; end
        6: begin sk = 2'd1; ht = 13'd3; end
        7: sk = 2'd0;
        8: begin nz = 8'd1; sk = 2'd3; ht = 13'd4096; end
        9: begin sk = 2'd2; ht = 13'd5000; end
        default: ;
      endcase
      set_config(nz, sk, ht);
      no_idle = (p == 5 || p == 7);
      // Back the block up: long receiver hold-off with short frames.
      if (p == 3) long_hold_req = 1'b1;
      h_eff = (ht > MaxRows) ? MaxRows : ht;
      span_hi = (h_eff + 4 > 4095) ? 4095 : h_eff + 4;
      if (span_hi < 8) span_hi = 8;
      phase_items = 0;
      while (phase_items < PhaseItems) begin
        len = (p == 3) ? $urandom_range(1, 3) : $urandom_range(1, 40);
        queue_frame(len, span_hi);
        phase_items += len;
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
